// ===== src/mobm_pkg.sv =====
// shared types and constants for the max overlap box match block
// no dependencies; imported by every module under src

package mobm_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int COORD_BITS  = 12;

    localparam int FIELD_BITS  = 12;
    localparam int MIDX_BITS   = 7;
    localparam int MAREA_BITS  = 24;

    localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
    localparam int AREA_BITS   = 2 * COORD_BITS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic signed [MIDX_BITS-1:0] NO_MATCH = -7'sd1;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_QUERY
    } op_t;

    typedef struct packed {
        logic [1:0]            command;
        logic [FIELD_BITS-1:0] box_x;
        logic [FIELD_BITS-1:0] box_y;
        logic [FIELD_BITS-1:0] box_width;
        logic [FIELD_BITS-1:0] box_height;
    } in_beat_t;

    typedef struct packed {
        logic signed [MIDX_BITS-1:0] match_index;
        logic [MAREA_BITS-1:0]       best_area;
    } out_beat_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
    } box_t;

    typedef struct packed {
        op_t  op;
        box_t box;
    } q_entry_t;

    // low COORD_BITS of a 12-bit field, zero extended when COORD_BITS is wider
    function automatic logic [COORD_BITS-1:0] to_coord(input logic [FIELD_BITS-1:0] v);
        logic [COORD_BITS+FIELD_BITS-1:0] ext;
        ext = (COORD_BITS + FIELD_BITS)'(v);
        return ext[COORD_BITS-1:0];
    endfunction

endpackage

// ===== src/max_overlap_box_match.sv =====
// top level of the max overlap box match block
// depends on mobm_pkg, mobm_front and mobm_back
//
// usage:
//   input channel s_valid / s_ready / s_data carries one command beat:
//   clear the target table, append one target box, or query a box
//   the unused command code is accepted and ignored
//   result channel m_valid / m_ready / m_data carries one beat per query:
//   index of the first target with the largest nonzero overlap (-1 if none)
//   and that overlap area; clear and append produce no result beat
// timing:
//   a four-entry command queue decouples the front end from the table scan
//   clear and append retire at the back end as soon as they are popped
//   a query reads one table entry per cycle for each stored target, through
//   read, extent, multiply and compare stages and the hand-off to the
//   output register
//   queries are serviced one at a time: the next command is not popped
//   until the result of the last query has entered the output register
// reset: aresetn low on a clock edge empties the queue and the table count
//   and drops any pending result; table contents are not cleared
// stall: the result register holds while m_ready is low; the queue keeps
//   taking beats until it fills, then s_ready drops

module max_overlap_box_match
    import mobm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    // command queue between decode and table scan
    logic     q_valid;
    logic     q_pop;
    q_entry_t q_entry;

    // decode and buffering of incoming beats
    mobm_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop)
    );

    // table storage, overlap pipeline and result beat
    mobm_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== src/mobm_front.sv =====
// front end: accepts input beats, decodes the command and queues work
// depends on mobm_pkg

module mobm_front
    import mobm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_beat_t s_data,
    output logic     q_valid,
    output q_entry_t q_entry,
    input  logic     q_pop
);

    q_entry_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]  fill_reg, fill_next;

    logic     accept;
    logic     push;
    logic     pop;
    q_entry_t decoded;

    assign s_ready = (fill_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign accept  = s_valid && s_ready;
    assign q_valid = (fill_reg != '0);
    assign q_entry = queue_reg[rd_ptr_reg];
    assign pop     = q_pop && q_valid;

    // unused command code is taken and dropped here
    always_comb begin
        decoded.box.x = to_coord(s_data.box_x);
        decoded.box.y = to_coord(s_data.box_y);
        decoded.box.w = to_coord(s_data.box_width);
        decoded.box.h = to_coord(s_data.box_height);
        decoded.op    = OP_CLEAR;
        push          = 1'b0;
        case (s_data.command)
            CMD_CLEAR: begin
                decoded.op = OP_CLEAR;
                push       = accept;
            end
            CMD_APPEND: begin
                decoded.op = OP_APPEND;
                push       = accept;
            end
            CMD_QUERY: begin
                decoded.op = OP_QUERY;
                push       = accept;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// ===== src/mobm_back.sv =====
// back end: target table, overlap scan pipeline and result register
// depends on mobm_pkg

module mobm_back
    import mobm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    input  q_entry_t  q_entry,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    localparam int IEXT_BITS = IDX_BITS + MIDX_BITS;
    localparam int AEXT_BITS = AREA_BITS + MAREA_BITS;

    state_t state_reg, state_next;

    box_t                  table_mem [TABLE_DEPTH];
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [CNT_BITS-1:0]   scan_reg, scan_next;
    box_t                  qbox_reg, qbox_next;

    // stage 1: table read
    box_t                  rd_box_reg;
    logic                  v1_reg, v1_next;
    logic [IDX_BITS-1:0]   idx1_reg, idx1_next;
    // stage 2: overlap extents
    logic [COORD_BITS-1:0] dx_reg, dx_next;
    logic [COORD_BITS-1:0] dy_reg, dy_next;
    logic                  v2_reg;
    logic [IDX_BITS-1:0]   idx2_reg;
    // stage 3: area
    logic [AREA_BITS-1:0]  area_reg, area_next;
    logic                  v3_reg;
    logic [IDX_BITS-1:0]   idx3_reg;
    // running best
    logic [AREA_BITS-1:0]  best_area_reg, best_area_next;
    logic [IDX_BITS-1:0]   best_idx_reg, best_idx_next;
    logic                  hit_reg, hit_next;

    logic                  m_valid_reg, m_valid_next;
    out_beat_t             m_data_reg, m_data_next;

    logic                  issue;
    logic                  do_append;
    logic [COORD_BITS:0]   left, right, top, bottom;
    logic [COORD_BITS:0]   q_r, q_b, t_r, t_b;
    logic [COORD_BITS:0]   dx_full, dy_full;
    logic [IEXT_BITS-1:0]  idx_ext;
    logic [AEXT_BITS-1:0]  area_ext;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign q_pop     = q_valid && (state_reg == S_IDLE);
    assign do_append = q_pop && (q_entry.op == OP_APPEND) &&
                       (count_reg != CNT_BITS'(TABLE_DEPTH));
    assign issue     = (state_reg == S_SCAN) && (scan_reg != count_reg);

    // overlap extents vs the entry just read, and area of registered extents
    always_comb begin
        q_r    = {1'b0, qbox_reg.x} + {1'b0, qbox_reg.w};
        q_b    = {1'b0, qbox_reg.y} + {1'b0, qbox_reg.h};
        t_r    = {1'b0, rd_box_reg.x} + {1'b0, rd_box_reg.w};
        t_b    = {1'b0, rd_box_reg.y} + {1'b0, rd_box_reg.h};
        left   = (qbox_reg.x > rd_box_reg.x) ? {1'b0, qbox_reg.x} : {1'b0, rd_box_reg.x};
        top    = (qbox_reg.y > rd_box_reg.y) ? {1'b0, qbox_reg.y} : {1'b0, rd_box_reg.y};
        right  = (q_r < t_r) ? q_r : t_r;
        bottom = (q_b < t_b) ? q_b : t_b;
        dx_full = (right > left) ? right - left : '0;
        dy_full = (bottom > top) ? bottom - top : '0;
        dx_next = dx_full[COORD_BITS-1:0];
        dy_next = dy_full[COORD_BITS-1:0];
        area_next = dx_reg * dy_reg;
    end

    always_comb begin
        idx_ext  = IEXT_BITS'(best_idx_reg);
        area_ext = AEXT_BITS'(best_area_reg);
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        qbox_next      = qbox_reg;
        v1_next        = issue;
        idx1_next      = scan_reg[IDX_BITS-1:0];
        best_area_next = best_area_reg;
        best_idx_next  = best_idx_reg;
        hit_next       = hit_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        if (v3_reg && (area_reg > best_area_reg)) begin
            best_area_next = area_reg;
            best_idx_next  = idx3_reg;
            hit_next       = 1'b1;
        end

        case (state_reg)
            S_IDLE: begin
                if (q_pop) begin
                    case (q_entry.op)
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        OP_APPEND: begin
                            if (do_append) begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_QUERY: begin
                            qbox_next      = q_entry.box;
                            scan_next      = '0;
                            best_area_next = '0;
                            best_idx_next  = '0;
                            hit_next       = 1'b0;
                            state_next     = S_SCAN;
                        end
                        default: begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (issue) begin
                    scan_next = scan_reg + 1'b1;
                end else if (!v1_reg && !v2_reg && !v3_reg) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next.match_index = hit_reg ?
                        signed'(idx_ext[MIDX_BITS-1:0]) : NO_MATCH;
                    m_data_next.best_area   = area_ext[MAREA_BITS-1:0];
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            scan_reg    <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            scan_reg    <= scan_next;
            v1_reg      <= v1_next;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            hit_reg     <= hit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        qbox_reg      <= qbox_next;
        idx1_reg      <= idx1_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        idx2_reg      <= idx1_reg;
        area_reg      <= area_next;
        idx3_reg      <= idx2_reg;
        best_area_reg <= best_area_next;
        best_idx_reg  <= best_idx_next;
        m_data_reg    <= m_data_next;
    end

    // target table
    always_ff @(posedge aclk) begin
        if (do_append) begin
            table_mem[count_reg[IDX_BITS-1:0]] <= q_entry.box;
        end
        if (issue) begin
            rd_box_reg <= table_mem[scan_reg[IDX_BITS-1:0]];
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(TABLE_DEPTH))
        else $error("target count above table depth");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (scan_reg <= count_reg))
        else $error("scan pointer past target count");

    a_pipe_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg || v2_reg || v3_reg) |-> (state_reg == S_SCAN))
        else $error("scan pipeline busy outside a query");

    // hit flag is stale once back in idle, where a clear may shrink the count
    a_hit_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (hit_reg && (state_reg != S_IDLE)) |-> (CNT_BITS'(best_idx_reg) < count_reg))
        else $error("best index beyond stored targets");

    a_result_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result presented before scan drained");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// self-checking bench for max_overlap_box_match: clear, append and query beats in,
// best overlap index and area out; depends on mobm_pkg and the block's rtl only

module testbench;
    import mobm_pkg::*;

    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam int         LIMIT_CYCLES  = 1_000_000;
    localparam int         SETTLE_CYCLES = 400;   // covers a full queue of full-table scans

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    // idle rates in percent, changed between phases only
    int send_idle_pct = 30;
    int recv_idle_pct = 87;

    in_beat_t  pending_beats[$];       // beats waiting to be driven
    out_beat_t expected_matches[$];    // predicted results, oldest first

    // predictor state: its own copy of the target table
    box_t        target_boxes[TABLE_DEPTH];
    int unsigned target_total = 0;

    int cycle_count     = 0;
    int error_count     = 0;
    int beats_sent      = 0;
    int results_checked = 0;
    int dropped_appends = 0;
    int ignored_beats   = 0;
    int ties_seen       = 0;

    max_overlap_box_match DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // cycle count and run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("run limit of %0d cycles reached", LIMIT_CYCLES);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[cycle %0d] mismatch: %s", cycle_count, msg);
    endtask

    // axis-aligned overlap; edges are 13 bits so x + width never wraps
    function automatic logic [MAREA_BITS-1:0] overlap_area(input box_t p, input box_t q);
        logic [COORD_BITS:0] lo_x, lo_y, hi_x, hi_y, end_p, end_q;
        lo_x  = (p.x > q.x) ? {1'b0, p.x} : {1'b0, q.x};
        lo_y  = (p.y > q.y) ? {1'b0, p.y} : {1'b0, q.y};
        end_p = {1'b0, p.x} + {1'b0, p.w};
        end_q = {1'b0, q.x} + {1'b0, q.w};
        hi_x  = (end_p < end_q) ? end_p : end_q;
        end_p = {1'b0, p.y} + {1'b0, p.h};
        end_q = {1'b0, q.y} + {1'b0, q.h};
        hi_y  = (end_p < end_q) ? end_p : end_q;
        if (hi_x <= lo_x || hi_y <= lo_y)
            return '0;
        return MAREA_BITS'(hi_x - lo_x) * MAREA_BITS'(hi_y - lo_y);
    endfunction

    // applies one accepted beat to the table copy and queues any result
    function automatic void predict_command(input in_beat_t beat);
        box_t                  probe;
        out_beat_t             best;
        logic [MAREA_BITS-1:0] area;
        probe = '{beat.box_x, beat.box_y, beat.box_width, beat.box_height};
        case (beat.command)
            CMD_CLEAR: begin
                target_total = 0;   // stale entries stay but are never scanned
            end
            CMD_APPEND: begin
                if (target_total < TABLE_DEPTH) begin
                    target_boxes[target_total] = probe;
                    target_total++;
                end else begin
                    dropped_appends++;
                end
            end
            CMD_QUERY: begin
                best.match_index = NO_MATCH;
                best.best_area   = '0;
                for (int i = 0; i < target_total; i++) begin
                    area = overlap_area(probe, target_boxes[i]);
                    if (area > best.best_area) begin
                        best.match_index = MIDX_BITS'(i);
                        best.best_area   = area;
                    end else if (area != 0 && area == best.best_area) begin
                        ties_seen++;   // earlier index keeps the win
                    end
                end
                expected_matches = {expected_matches, best};
            end
            default: begin
                ignored_beats++;
            end
        endcase
    endfunction

    // driver: predicts on each accepted beat, then offers the next one
    always @(posedge aclk) begin : drive_beats
        logic     next_valid;
        in_beat_t next_data;
        next_valid = s_valid;
        next_data  = s_data;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_command(s_data);
                beats_sent++;
                next_valid = 1'b0;
            end
            // a held beat keeps valid high; only an empty slot may idle
            if (!next_valid && pending_beats.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                next_valid = 1'b1;
                next_data  = pending_beats.pop_front();
            end
        end
        s_valid <= next_valid;
        s_data  <= next_data;
    end

    // monitor: every result beat against the oldest prediction
    always @(posedge aclk) begin : check_results
        out_beat_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_matches.size() == 0) begin
                    report_mismatch($sformatf("unexpected result index %0d area %0d",
                                              m_data.match_index, m_data.best_area));
                end else begin
                    want = expected_matches.pop_front();
                    results_checked++;
                    if (m_data.match_index !== want.match_index)
                        report_mismatch($sformatf("match_index %0d, predicted %0d",
                                                  m_data.match_index, want.match_index));
                    if (m_data.best_area !== want.best_area)
                        report_mismatch($sformatf("best_area %0d, predicted %0d",
                                                  m_data.best_area, want.best_area));
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic add_beat(input logic [1:0] cmd, input box_t b);
        in_beat_t beat;
        beat.command    = cmd;
        beat.box_x      = b.x;
        beat.box_y      = b.y;
        beat.box_width  = b.w;
        beat.box_height = b.h;
        pending_beats = {pending_beats, beat};
    endtask

    // mostly boxes in a small region so overlaps are common, plus full-range
    // values, corner values and degenerate sizes
    function automatic box_t random_box();
        box_t b;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            b = '{COORD_BITS'($urandom_range(0, 400)), COORD_BITS'($urandom_range(0, 400)),
                  COORD_BITS'($urandom_range(0, 160)), COORD_BITS'($urandom_range(0, 160))};
        end else if (pick < 85) begin
            b = '{COORD_BITS'($urandom), COORD_BITS'($urandom),
                  COORD_BITS'($urandom), COORD_BITS'($urandom)};
        end else if (pick < 95) begin
            b.x = $urandom_range(0, 1) ? '1 : '0;
            b.y = $urandom_range(0, 1) ? '1 : '0;
            b.w = $urandom_range(0, 1) ? '1 : '0;
            b.h = $urandom_range(0, 1) ? '1 : '0;
        end else begin
            b = '{COORD_BITS'($urandom_range(0, 400)), COORD_BITS'($urandom_range(0, 400)),
                  COORD_BITS'($urandom_range(0, 160)), COORD_BITS'($urandom_range(0, 160))};
            if ($urandom_range(0, 1)) b.w = '0;
            else                      b.h = '0;
        end
        return b;
    endfunction

    // random traffic as load-then-query sequences; reusing recent boxes
    // gives exact matches and ties
    task automatic queue_random_traffic(input int item_goal);
        box_t recent_boxes[$];
        box_t b;
        int   pushed;
        int   n_append;
        int   n_query;
        pushed = 0;
        while (pushed < item_goal) begin
            if ($urandom_range(0, 99) < 35) begin
                add_beat(CMD_CLEAR, random_box());
                pushed++;
            end
            // now and then a run long enough to hit the full table
            n_append = ($urandom_range(0, 99) < 8) ? $urandom_range(40, 70)
                                                    : $urandom_range(0, 8);
            for (int i = 0; i < n_append; i++) begin
                if (recent_boxes.size() != 0 && $urandom_range(0, 99) < 15)
                    b = recent_boxes[$urandom_range(0, recent_boxes.size() - 1)];
                else
                    b = random_box();
                add_beat(CMD_APPEND, b);
                recent_boxes = {recent_boxes, b};
                if (recent_boxes.size() > 16) void'(recent_boxes.pop_front());
                pushed++;
            end
            n_query = $urandom_range(1, 5);
            for (int i = 0; i < n_query; i++) begin
                if (recent_boxes.size() != 0 && $urandom_range(0, 99) < 25)
                    b = recent_boxes[$urandom_range(0, recent_boxes.size() - 1)];
                else
                    b = random_box();
                add_beat(CMD_QUERY, b);
                pushed++;
            end
            // unused command code as noise, not counted
            if ($urandom_range(0, 99) < 5)
                add_beat(CMD_UNUSED, random_box());
        end
    endtask

    // all beats driven and every predicted result received
    task automatic wait_drained();
        while (pending_beats.size() != 0 || s_valid || expected_matches.size() != 0)
            @(posedge aclk);
    endtask

    initial begin : stimulus
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, extremes, degenerate boxes, ties, edges
        add_beat(CMD_QUERY,  '{12'd10, 12'd10, 12'd20, 12'd20});      // empty table
        add_beat(CMD_UNUSED, '{'1, '1, '1, '1});                      // ignored code
        add_beat(CMD_APPEND, '{'1, '1, '1, '1});                      // far corner, max size
        add_beat(CMD_APPEND, '{'0, '0, '1, '1});                      // whole frame
        add_beat(CMD_APPEND, '{12'd100, 12'd100, 12'd0, 12'd50});     // zero width
        add_beat(CMD_APPEND, '{12'd100, 12'd100, 12'd50, 12'd0});     // zero height
        add_beat(CMD_QUERY,  '{'0, '0, '1, '1});                      // largest area
        add_beat(CMD_QUERY,  '{'1, '1, '1, '1});                      // only the corner box
        add_beat(CMD_QUERY,  '{12'd100, 12'd100, 12'd50, 12'd50});
        add_beat(CMD_APPEND, '{12'd200, 12'd200, 12'd30, 12'd30});
        add_beat(CMD_APPEND, '{12'd200, 12'd200, 12'd30, 12'd30});    // duplicate for a tie
        add_beat(CMD_QUERY,  '{12'd210, 12'd210, 12'd100, 12'd100});
        add_beat(CMD_QUERY,  '{12'd230, 12'd230, 12'd10, 12'd10});    // touching edges
        add_beat(CMD_QUERY,  '{12'd210, 12'd210, 12'd0, 12'd0});      // zero-size query
        add_beat(CMD_CLEAR,  '{'0, '0, '0, '0});
        add_beat(CMD_QUERY,  '{'0, '0, '1, '1});                      // after clear
        add_beat(CMD_APPEND, '{'0, '0, '1, '1});                      // overwrites stale slot
        add_beat(CMD_QUERY,  '{12'd1, 12'd1, 12'd1, 12'd1});
        add_beat(CMD_CLEAR,  '{'1, '1, '1, '1});
        // fill the table and push one past capacity
        for (int i = 0; i <= TABLE_DEPTH; i++)
            add_beat(CMD_APPEND, '{COORD_BITS'(i * 8), COORD_BITS'(i * 8), 12'd40, 12'd40});
        add_beat(CMD_QUERY,  '{12'd500, 12'd500, 12'd20, 12'd20});    // slot 60 wins a tie
        add_beat(CMD_QUERY,  '{12'd0, 12'd0, 12'd600, 12'd600});
        add_beat(CMD_CLEAR,  '{'0, '0, '0, '0});

        // phase one: sender idles lightly, receiver stalls hard
        queue_random_traffic(560);
        wait_drained();

        // phase two: the other way round
        send_idle_pct = 87;
        recv_idle_pct = 30;
        queue_random_traffic(570);
        wait_drained();

        // phase three: full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_traffic(570);
        wait_drained();

        // trailing appends may still sit in the block's queue; catch stray results
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_matches.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      expected_matches.size()));

        $display("coverage: %0d command beats, %0d match results checked, %0d ties",
                 beats_sent, results_checked, ties_seen);
        $display("coverage: %0d appends dropped on a full table, %0d unused-code beats",
                 dropped_appends, ignored_beats);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
